/* design/tsf_pkg.sv */
// Shared types, codes and constants of the timestamp section filter.
`default_nettype none
package tsf_pkg;

	localparam int MAX_SECTIONS_DEF = 16;
	localparam int TIME_BITS = 48;
	localparam int LEN_W = 47;
	localparam int KIND_W = 2;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
	localparam logic signed [TIME_BITS-1:0] T_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};
	localparam logic signed [TIME_BITS-1:0] T_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_DONE = 3'd0,
		ST_NO_SECTIONS = 3'd1,
		ST_INSIDE = 3'd2,
		ST_GAP_DROP = 3'd3,
		ST_PAST_END = 3'd4,
		ST_START_IGNORED = 3'd5,
		ST_FULL = 3'd6,
		ST_BAD_INDEX = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_SETUP,
		CS_WALK,
		CS_TAIL,
		CS_COMMIT,
		CS_OUT
	} ctl_state_t;

	typedef enum logic [1:0] {
		PH_BEFORE,
		PH_MERGING,
		PH_AFTER
	} phase_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic signed [TIME_BITS-1:0] start_time;
		logic [LEN_W-1:0] span;
		logic [7:0] entry_index;
		logic signed [TIME_BITS-1:0] packet_pts;
		logic signed [TIME_BITS-1:0] packet_dts;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] hit_section;
		logic signed [TIME_BITS-1:0] pts_out;
		logic signed [TIME_BITS-1:0] dts_out;
		logic [4:0] entry_count;
		logic [LEN_W-1:0] selected_total;
	} out_item_t;

	typedef struct packed {
		logic load_in;
		logic setup;
		logic walk;
		logic tail;
		logic commit;
		logic load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic early;
		logic walk_end;
		logic need_tail;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

/* design/tsf_ctrl.sv */
// Sequencing state machine of the timestamp section filter.
`default_nettype none
module tsf_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire tsf_pkg::dp_stat_t stat,
	output tsf_pkg::ctl_cmd_t cmd
);
	import tsf_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			CS_IDLE: begin
				if (in_valid) state_next = CS_SETUP;
			end
			CS_SETUP: begin
				state_next = stat.early ? CS_OUT : CS_WALK;
			end
			CS_WALK: begin
				if (stat.walk_end) begin
					if (stat.kind == KIND_QUERY) state_next = CS_OUT;
					else if (stat.need_tail) state_next = CS_TAIL;
					else state_next = CS_COMMIT;
				end
			end
			CS_TAIL: state_next = CS_COMMIT;
			CS_COMMIT: state_next = CS_OUT;
			CS_OUT: begin
				if (stat.out_free) state_next = CS_IDLE;
			end
			default: state_next = CS_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = (state_q != CS_IDLE);
		case (state_q)
			CS_IDLE: cmd.load_in = in_valid;
			CS_SETUP: cmd.setup = 1'b1;
			CS_WALK: cmd.walk = 1'b1;
			CS_TAIL: cmd.tail = 1'b1;
			CS_COMMIT: cmd.commit = 1'b1;
			CS_OUT: cmd.load_out = stat.out_free;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

/* design/tsf_dp.sv */
// Datapath of the timestamp section filter: section memory, walk logic and result register.
`default_nettype none
module tsf_dp #(
	parameter int MAX_SECTIONS = tsf_pkg::MAX_SECTIONS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire tsf_pkg::in_item_t in_data,
	input wire logic cfg_valid,
	input wire logic [tsf_pkg::LEN_W-1:0] cfg_data,
	input wire logic out_stall,
	output logic out_valid,
	output tsf_pkg::out_item_t out_data,
	input wire tsf_pkg::ctl_cmd_t cmd,
	output tsf_pkg::dp_stat_t stat
);
	import tsf_pkg::*;

	localparam int CW = $clog2(MAX_SECTIONS + 1);
	localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int XW = (CW > 8) ? CW : 8;
	localparam int DEPTH = 2 * (2 ** AW);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_SECTIONS);

	// Two banks: the table is rebuilt into the idle bank and then swapped in.
	logic signed [TIME_BITS-1:0] mem_b [DEPTH];
	logic signed [TIME_BITS-1:0] mem_e [DEPTH];
	logic signed [TIME_BITS-1:0] rd_b, rd_e;
	logic bank_q;

	logic [LEN_W-1:0] media_q;
	logic [CW-1:0] count_q;
	logic [LEN_W-1:0] total_q;

	in_item_t item_q;
	logic [2:0] res_q;
	logic inside_q;
	logic [CW-1:0] i_q, n_q;
	phase_t phase_q;
	logic signed [TIME_BITS-1:0] sf_q, st_q, prev_e_q;
	logic signed [TIME_BITS:0] gaps_q;
	logic full_q;
	logic [LEN_W-1:0] acc_q, delta_s1;
	logic out_valid_q;
	out_item_t out_q;

	logic adv, wr_en;
	logic signed [TIME_BITS-1:0] wr_b, wr_e;
	logic [CW-1:0] rd_idx;
	logic [AW:0] rd_addr, wr_addr;
	logic at_end;

	// Setup terms.
	logic start_ge_len;
	logic signed [TIME_BITS-1:0] sf_init;
	logic [TIME_BITS:0] st_sum;
	logic signed [TIME_BITS-1:0] st_init;
	logic early;
	logic [2:0] early_res;

	// Walk terms.
	logic signed [TIME_BITS-1:0] sf_use, st_new, sf_new;
	phase_t phase_new;
	logic q_gap, q_hit;
	logic signed [TIME_BITS:0] gaps_next;
	logic signed [TIME_BITS:0] wdelta;
	logic [LEN_W-1:0] wdelta_clip;
	logic [LEN_W:0] acc_sum;
	logic [LEN_W-1:0] acc_next;

	// Result terms.
	logic signed [TIME_BITS+1:0] dts_diff;
	logic signed [TIME_BITS-1:0] pts_adj, dts_adj;

	assign at_end = (i_q == count_q);

	always_comb begin
		start_ge_len = ($signed({item_q.start_time[TIME_BITS-1], item_q.start_time})
			>= $signed({2'b00, media_q}));
		sf_init = item_q.start_time[TIME_BITS-1] ? '0 : item_q.start_time;
		st_sum = {1'b0, sf_init} + {2'b00, item_q.span};
		if ((item_q.span == '0) || (st_sum > {2'b00, media_q})) begin
			st_init = {1'b0, media_q};
		end else begin
			st_init = st_sum[TIME_BITS-1:0];
		end
		early = 1'b0;
		early_res = ST_DONE;
		case (item_q.kind)
			KIND_INSERT: begin
				early = start_ge_len;
				early_res = ST_START_IGNORED;
			end
			KIND_REMOVE: begin
				early = (XW'(item_q.entry_index) >= XW'(count_q));
				early_res = ST_BAD_INDEX;
			end
			KIND_QUERY: begin
				early = (count_q == '0);
				early_res = ST_NO_SECTIONS;
			end
			default: begin
				early = 1'b1;
				early_res = ST_DONE;
			end
		endcase
	end

	always_comb begin
		adv = 1'b0;
		wr_en = 1'b0;
		wr_b = rd_b;
		wr_e = rd_e;
		sf_use = sf_q;
		sf_new = sf_q;
		st_new = st_q;
		phase_new = phase_q;
		q_gap = 1'b0;
		q_hit = 1'b0;
		gaps_next = gaps_q + $signed({rd_b[TIME_BITS-1], rd_b})
			- $signed({prev_e_q[TIME_BITS-1], prev_e_q});
		if (cmd.tail) begin
			wr_en = 1'b1;
			wr_b = sf_q;
			wr_e = st_q;
		end else if (cmd.walk && !at_end) begin
			case (item_q.kind)
				KIND_INSERT: begin
					if (phase_q == PH_AFTER) begin
						wr_en = 1'b1;
						adv = 1'b1;
					end else begin
						logic merging;
						merging = (phase_q == PH_MERGING);
						if (phase_q == PH_BEFORE) begin
							if (rd_b > sf_q) begin
								merging = 1'b1;
							end else if (rd_e > sf_q) begin
								merging = 1'b1;
								sf_use = rd_b;
							end else begin
								wr_en = 1'b1;
								adv = 1'b1;
							end
						end
						if (merging) begin
							sf_new = sf_use;
							if (rd_b >= st_q) begin
								wr_en = 1'b1;
								wr_b = sf_use;
								wr_e = st_q;
								phase_new = PH_AFTER;
							end else if (rd_e >= st_q) begin
								wr_en = 1'b1;
								wr_b = sf_use;
								wr_e = rd_e;
								st_new = rd_e;
								phase_new = PH_AFTER;
								adv = 1'b1;
							end else begin
								phase_new = PH_MERGING;
								adv = 1'b1;
							end
						end
					end
				end
				KIND_REMOVE: begin
					wr_en = (XW'(i_q) != XW'(item_q.entry_index));
					adv = 1'b1;
				end
				default: begin
					if (item_q.packet_pts < rd_b) begin
						q_gap = 1'b1;
					end else if (item_q.packet_pts < rd_e) begin
						q_hit = 1'b1;
					end else begin
						adv = 1'b1;
					end
				end
			endcase
		end
	end

	// The walk always starts from the first entry, so setup reads entry zero.
	assign rd_idx = cmd.setup ? '0 : (adv ? (i_q + 1'b1) : i_q);
	assign rd_addr = {bank_q, rd_idx[AW-1:0]};
	assign wr_addr = {~bank_q, n_q[AW-1:0]};

	// Entry length, clipped to the length range, is registered in delta_s1 before it feeds the running total.
	assign wdelta = $signed({wr_e[TIME_BITS-1], wr_e}) - $signed({wr_b[TIME_BITS-1], wr_b});
	always_comb begin
		if (wdelta[TIME_BITS]) wdelta_clip = '0;
		else if (wdelta[TIME_BITS-1:0] > {1'b0, LEN_MAX}) wdelta_clip = LEN_MAX;
		else wdelta_clip = wdelta[LEN_W-1:0];
		acc_sum = {1'b0, acc_q} + {1'b0, delta_s1};
		acc_next = acc_sum[LEN_W] ? LEN_MAX : acc_sum[LEN_W-1:0];
	end

	always_ff @(posedge clk) begin
		rd_b <= mem_b[rd_addr];
		rd_e <= mem_e[rd_addr];
		if (wr_en && (n_q != MAX_C) && item_q.kind != KIND_QUERY) begin
			mem_b[wr_addr] <= wr_b;
			mem_e[wr_addr] <= wr_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			media_q <= '0;
			count_q <= '0;
			total_q <= '0;
			bank_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) media_q <= cfg_data;
			if (cmd.commit && !full_q) begin
				bank_q <= ~bank_q;
				count_q <= n_q;
				total_q <= acc_next;
			end
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) item_q <= in_data;
		if (cmd.setup) begin
			res_q <= early_res;
			inside_q <= 1'b0;
			i_q <= '0;
			n_q <= '0;
			phase_q <= PH_BEFORE;
			sf_q <= sf_init;
			st_q <= st_init;
			prev_e_q <= '0;
			gaps_q <= '0;
			full_q <= 1'b0;
			acc_q <= '0;
			delta_s1 <= '0;
		end else begin
			acc_q <= acc_next;
			delta_s1 <= '0;
			if (wr_en && item_q.kind != KIND_QUERY) begin
				if (n_q == MAX_C) begin
					full_q <= 1'b1;
				end else begin
					n_q <= n_q + 1'b1;
					delta_s1 <= wdelta_clip;
				end
			end
			if (cmd.walk) begin
				if (adv) i_q <= i_q + 1'b1;
				sf_q <= sf_new;
				st_q <= st_new;
				phase_q <= phase_new;
				if (item_q.kind == KIND_QUERY) begin
					if (at_end) begin
						res_q <= ST_PAST_END;
					end else if (q_gap) begin
						res_q <= ST_GAP_DROP;
					end else if (q_hit) begin
						res_q <= ST_INSIDE;
						inside_q <= 1'b1;
						gaps_q <= gaps_next;
					end else begin
						gaps_q <= gaps_next;
						prev_e_q <= rd_e;
					end
				end
			end
			if (cmd.commit) res_q <= full_q ? ST_FULL : ST_DONE;
		end
		if (cmd.load_out) begin
			out_q.status <= res_q;
			out_q.hit_section <= inside_q ? 8'(i_q) : 8'd0;
			out_q.entry_count <= 5'(count_q);
			out_q.selected_total <= (total_q == '0) ? media_q : total_q;
			if (item_q.kind != KIND_QUERY) begin
				out_q.pts_out <= '0;
				out_q.dts_out <= '0;
			end else if (inside_q) begin
				out_q.pts_out <= pts_adj;
				out_q.dts_out <= dts_adj;
			end else begin
				out_q.pts_out <= item_q.packet_pts;
				out_q.dts_out <= item_q.packet_dts;
			end
		end
	end

	// Shifted timestamps; dts saturates to the timestamp range.
	always_comb begin
		logic signed [TIME_BITS:0] pts_full;
		pts_full = $signed({item_q.packet_pts[TIME_BITS-1], item_q.packet_pts}) - gaps_q;
		pts_adj = pts_full[TIME_BITS-1:0];
		dts_diff = $signed({{2{item_q.packet_dts[TIME_BITS-1]}}, item_q.packet_dts})
			- $signed({gaps_q[TIME_BITS], gaps_q});
		if (dts_diff < $signed({{2{1'b1}}, T_MIN})) dts_adj = T_MIN;
		else if (dts_diff > $signed({2'b00, T_MAX})) dts_adj = T_MAX;
		else dts_adj = dts_diff[TIME_BITS-1:0];
	end

	always_comb begin
		stat.kind = item_q.kind;
		stat.early = early;
		stat.walk_end = at_end || q_gap || q_hit;
		// Only an insert that has not placed its new section yet appends it at the end.
		stat.need_tail = (item_q.kind == KIND_INSERT) && (phase_q != PH_AFTER);
		stat.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_C) else $error("section count above table size");
	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a pending result");
	a_commit_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !full_q) |=> (count_q <= MAX_C))
		else $error("committed table exceeds capacity");
`endif

endmodule
`default_nettype wire

/* design/timestamp_section_filter_top.sv */
// Top level of the timestamp section filter: controller, datapath and ports.
`default_nettype none
// The block holds a sorted table of up to MAX_SECTIONS disjoint time sections in
// time-base ticks and takes one request at a time. An insert clamps the section to
// the media length and merges it with every entry it overlaps; a remove erases one
// entry by position; a query classifies a packet pts and shifts pts and dts back by
// the summed gaps ahead of the section that holds it. Each request walks the table
// one entry per cycle through a registered-read section memory. After setup an insert
// walks, may append its section in a tail step, commits and outputs; a remove walks,
// commits and outputs; a query walks up to its section or gap and outputs. Rejected
// requests (start past the end, bad index, empty table, unused kind) go from setup
// straight to output. A result that is still held by the receiver delays the next
// result and so the next request. The table is rebuilt into a second memory bank and
// swapped in on completion, so a full-table insert leaves the old table untouched.
// The result register frees the input side: a new request is taken while the previous
// result waits. The user must write media_length on the configuration port only
// while idle; the block does not enforce it. A write never alters stored sections.
module timestamp_section_filter_top #(
	parameter int MAX_SECTIONS = tsf_pkg::MAX_SECTIONS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire tsf_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output tsf_pkg::out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [tsf_pkg::LEN_W-1:0] cfg_data
);
	import tsf_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// The length register is always ready to take a write.
	assign cfg_ready = 1'b1;

	tsf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat(stat),
		.cmd(cmd)
	);

	tsf_dp #(
		.MAX_SECTIONS(MAX_SECTIONS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.cfg_valid(cfg_valid),
		.cfg_data(cfg_data),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_data(out_data),
		.cmd(cmd),
		.stat(stat)
	);

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench of the timestamp section filter: a local section-table predictor checks every result.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tsf_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LEN_W-1:0] cfg_data = '0;

	timestamp_section_filter_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// The clock runs at 10 ns, high then low.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The predictor keeps its own copy of the section table and the media length.
	logic signed [63:0] sec_lo [TABLE_DEPTH];
	logic signed [63:0] sec_hi [TABLE_DEPTH];
	int sec_count;
	logic [LEN_W-1:0] media_len;

	in_item_t pending_requests[$];
	out_item_t expected_results[$];
	int mismatches;
	int accepted_requests;
	int checked_results;
	int idle_cycles;
	int status_seen [8];

	// The receiver holds off for as long as this counts down; set by the stimulus.
	int hold_receiver;
	int send_wait;
	int recv_wait;

	// Sums the section lengths with saturation, falling back to the media length.
	function automatic logic [LEN_W-1:0] table_total();
		logic [63:0] sum;
		sum = 0;
		for (int i = 0; i < sec_count; i++) begin
			if (sec_hi[i] > sec_lo[i])
				sum += 64'(sec_hi[i] - sec_lo[i]);
			if (sum > 64'(LEN_MAX))
				sum = 64'(LEN_MAX);
		end
		if (sum == 0)
			sum = 64'(media_len);
		return sum[LEN_W-1:0];
	endfunction

	// Insert with clamping and merging; the table is left alone when it would overflow.
	function automatic status_t insert_section(logic signed [63:0] start, logic [63:0] span);
		logic signed [63:0] len, lo, hi, b, e;
		logic signed [63:0] nb [TABLE_DEPTH+1];
		logic signed [63:0] ne [TABLE_DEPTH+1];
		int n;
		phase_t ph;
		len = $signed(64'(media_len));
		n = 0;
		ph = PH_BEFORE;
		if (start >= len)
			return ST_START_IGNORED;
		lo = (start < 0) ? 64'sd0 : start;
		hi = lo + $signed(span);
		if (hi > len || span == 0)
			hi = len;
		for (int i = 0; i < sec_count; i++) begin
			b = sec_lo[i];
			e = sec_hi[i];
			if (ph == PH_BEFORE) begin
				if (b > lo) begin
					ph = PH_MERGING;
				end else if (e > lo) begin
					lo = b;
					ph = PH_MERGING;
				end else begin
					nb[n] = b; ne[n] = e; n++;
					continue;
				end
			end
			if (ph == PH_MERGING) begin
				if (b >= hi) begin
					nb[n] = lo; ne[n] = hi; n++;
					nb[n] = b; ne[n] = e; n++;
					ph = PH_AFTER;
				end else if (e >= hi) begin
					hi = e;
					nb[n] = lo; ne[n] = hi; n++;
					ph = PH_AFTER;
				end
			end else begin
				nb[n] = b; ne[n] = e; n++;
			end
		end
		if (ph != PH_AFTER) begin
			nb[n] = lo; ne[n] = hi; n++;
		end
		if (n > TABLE_DEPTH)
			return ST_FULL;
		for (int i = 0; i < n; i++) begin
			sec_lo[i] = nb[i];
			sec_hi[i] = ne[i];
		end
		sec_count = n;
		return ST_DONE;
	endfunction

	// Works out the result of one request and updates the table.
	function automatic out_item_t predict_section_result(in_item_t req);
		out_item_t res;
		logic signed [63:0] pts, dts, gaps, tmin, tmax;
		res = '0;
		tmax = 64'sd140737488355327;
		tmin = -tmax - 1;
		if (req.kind == KIND_INSERT) begin
			res.status = insert_section(64'(req.start_time), 64'(req.span));
		end else if (req.kind == KIND_REMOVE) begin
			if (int'(req.entry_index) < sec_count) begin
				for (int k = int'(req.entry_index); k + 1 < sec_count; k++) begin
					sec_lo[k] = sec_lo[k+1];
					sec_hi[k] = sec_hi[k+1];
				end
				sec_count--;
				res.status = ST_DONE;
			end else begin
				res.status = ST_BAD_INDEX;
			end
		end else if (req.kind == KIND_QUERY) begin
			pts = 64'(req.packet_pts);
			dts = 64'(req.packet_dts);
			res.pts_out = req.packet_pts;
			res.dts_out = req.packet_dts;
			if (sec_count == 0) begin
				res.status = ST_NO_SECTIONS;
			end else begin
				gaps = 0;
				res.status = ST_PAST_END;
				for (int i = 0; i < sec_count; i++) begin
					if (pts < sec_lo[i]) begin
						res.status = ST_GAP_DROP;
						break;
					end
					gaps += sec_lo[i];
					if (i > 0)
						gaps -= sec_hi[i-1];
					if (pts < sec_hi[i]) begin
						res.status = ST_INSIDE;
						res.hit_section = 8'(i);
						res.pts_out = TIME_BITS'(pts - gaps);
						if (gaps > 0 && dts < tmin + gaps)
							res.dts_out = T_MIN;
						else if (gaps < 0 && dts > tmax + gaps)
							res.dts_out = T_MAX;
						else
							res.dts_out = TIME_BITS'(dts - gaps);
						break;
					end
				end
			end
		end else begin
			res.status = ST_DONE;
		end
		res.entry_count = 5'(sec_count);
		res.selected_total = table_total();
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch on result %0d: %s got %0h, expected %0h",
			checked_results, what, got, want);
		mismatches++;
	endtask

	// The acceptance seen in the driver is sampled at the rising edge.
	logic in_taken = 1'b0;
	always @(posedge clk)
		in_taken <= in_valid && !in_stall;

	// Driver: presents requests at the falling edge and predicts each one on acceptance.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				expected_results.push_back(predict_section_result(in_data));
				accepted_requests++;
			end
			if (in_valid && !in_taken) begin
				// The request stays on the port until it is taken.
			end else if (send_wait > 0) begin
				send_wait <= send_wait - 1;
				in_valid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				in_data <= pending_requests.pop_front();
				in_valid <= 1'b1;
				send_wait <= $urandom_range(3) == 0 ? $urandom_range(19) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each result at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("result with no request waiting for it");
				mismatches++;
			end else begin
				automatic out_item_t want = expected_results.pop_front();
				if (out_data.status != want.status)
					report_mismatch("status", 64'(out_data.status), 64'(want.status));
				if (out_data.hit_section != want.hit_section)
					report_mismatch("hit_section", 64'(out_data.hit_section),
						64'(want.hit_section));
				if (out_data.pts_out != want.pts_out)
					report_mismatch("pts_out", 64'(out_data.pts_out), 64'(want.pts_out));
				if (out_data.dts_out != want.dts_out)
					report_mismatch("dts_out", 64'(out_data.dts_out), 64'(want.dts_out));
				if (out_data.entry_count != want.entry_count)
					report_mismatch("entry_count", 64'(out_data.entry_count),
						64'(want.entry_count));
				if (out_data.selected_total != want.selected_total)
					report_mismatch("selected_total", 64'(out_data.selected_total),
						64'(want.selected_total));
				status_seen[want.status]++;
			end
			checked_results++;
		end
	end

	// The receiver stalls from the falling edge, either per result or for a long hold.
	always @(negedge clk) begin
		if (hold_receiver > 0) begin
			hold_receiver <= hold_receiver - 1;
			out_stall <= 1'b1;
		end else if (recv_wait > 0) begin
			recv_wait <= recv_wait - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (out_valid)
				recv_wait <= $urandom_range(3) == 0 ? $urandom_range(19) : 0;
		end
	end

	// Watchdog: counts cycles with no request or result accepted.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Random signed time, mostly between zero and the media length plus 40.
	function automatic logic signed [TIME_BITS-1:0] rand_time(logic [LEN_W-1:0] len);
		case ($urandom_range(5))
			0: return TIME_BITS'({$urandom, $urandom});
			1: return -TIME_BITS'($urandom_range(1000));
			default: return TIME_BITS'($urandom_range(32'(len) + 40));
		endcase
	endfunction

	function automatic in_item_t rand_request(logic [LEN_W-1:0] len);
		in_item_t r;
		r = '0;
		r.start_time = rand_time(len);
		r.span = ($urandom_range(7) == 0) ? LEN_W'({$urandom, $urandom}) :
			LEN_W'($urandom_range(len / 8 + 2));
		r.entry_index = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(17));
		r.packet_pts = rand_time(len);
		r.packet_dts = ($urandom_range(5) == 0) ? TIME_BITS'({$urandom, $urandom}) :
			r.packet_pts - TIME_BITS'($urandom_range(30));
		case ($urandom_range(19))
			0: r.kind = KIND_UNUSED;
			1, 2, 3, 4, 5, 6: r.kind = KIND_INSERT;
			7, 8, 9: r.kind = KIND_REMOVE;
			default: r.kind = KIND_QUERY;
		endcase
		return r;
	endfunction

	function automatic in_item_t make_insert(logic signed [TIME_BITS-1:0] st,
			logic [LEN_W-1:0] sp);
		in_item_t r;
		r = '0;
		r.kind = KIND_INSERT;
		r.start_time = st;
		r.span = sp;
		return r;
	endfunction

	function automatic in_item_t make_query(logic signed [TIME_BITS-1:0] p,
			logic signed [TIME_BITS-1:0] d);
		in_item_t r;
		r = '0;
		r.kind = KIND_QUERY;
		r.packet_pts = p;
		r.packet_dts = d;
		return r;
	endfunction

	// Waits until every expected result has arrived and the block has settled.
	task automatic drain();
		wait (pending_requests.size() == 0 && !in_valid);
		@(posedge clk);
		wait (expected_results.size() == 0);
		repeat (30) @(posedge clk);
	endtask

	// Writes media_length while the block is idle.
	task automatic write_media_length(logic [LEN_W-1:0] len);
		@(negedge clk);
		cfg_data <= len;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		media_len = len;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		in_item_t r;
		logic [LEN_W-1:0] lengths [6];
		mismatches = 0;
		accepted_requests = 0;
		checked_results = 0;
		sec_count = 0;
		media_len = '0;
		hold_receiver = 0;
		send_wait = 0;
		recv_wait = 0;
		for (int i = 0; i < 8; i++)
			status_seen[i] = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part with a zero media length: empty table, empty section, bad index.
		pending_requests.push_back(make_query(48'sd5, 48'sd3));
		pending_requests.push_back(make_insert(-48'sd4, 47'd0));
		pending_requests.push_back(make_insert(48'sd0, 47'd5));
		r = '0; r.kind = KIND_REMOVE; r.entry_index = 8'd255;
		pending_requests.push_back(r);
		r.entry_index = 8'd0;
		pending_requests.push_back(r);
		drain();

		// Directed part at 1000 ticks: touching sections, merges, gaps, past end.
		write_media_length(47'd1000);
		pending_requests.push_back(make_insert(48'sd100, 47'd100));
		pending_requests.push_back(make_insert(48'sd200, 47'd50));
		pending_requests.push_back(make_insert(48'sd50, 47'd50));
		pending_requests.push_back(make_insert(48'sd400, 47'd100));
		pending_requests.push_back(make_insert(48'sd150, 47'd300));
		pending_requests.push_back(make_insert(48'sd900, 47'd5000));
		pending_requests.push_back(make_insert(48'sd1000, 47'd1));
		pending_requests.push_back(make_query(48'sd10, 48'sd9));
		pending_requests.push_back(make_query(48'sd60, T_MIN));
		pending_requests.push_back(make_query(48'sd920, T_MIN + 48'sd5));
		pending_requests.push_back(make_query(48'sd700, 48'sd700));
		pending_requests.push_back(make_query(T_MAX, T_MAX));
		pending_requests.push_back(make_query(T_MIN, T_MIN));
		r = '0; r.kind = KIND_UNUSED; r.start_time = T_MAX; r.span = LEN_MAX;
		r.entry_index = 8'hFF; r.packet_pts = -48'sd1; r.packet_dts = -48'sd1;
		pending_requests.push_back(r);
		// Seventeen short inserts spaced 50 ticks apart add to the table or merge into it.
		for (int i = 0; i < 17; i++)
			pending_requests.push_back(make_insert(48'(i * 50 + 1), 47'd10));
		drain();

		// Random phases over several media lengths, extremes included.
		lengths[0] = LEN_MAX;
		lengths[1] = 47'd0;
		lengths[2] = 47'd300;
		lengths[3] = 47'd5000;
		lengths[4] = LEN_MAX - 47'd7;
		lengths[5] = 47'd2000;
		for (int ph = 0; ph < 6; ph++) begin
			write_media_length(lengths[ph]);
			// Large lengths cap the random times at 100000 and give some requests a span near the maximum.
			for (int i = 0; i < 300; i++) begin
				r = rand_request(lengths[ph] > 47'd100000 ? 47'd100000 : lengths[ph]);
				if (lengths[ph] > 47'd100000 && $urandom_range(3) == 0)
					r.span = LEN_MAX - LEN_W'($urandom_range(100));
				pending_requests.push_back(r);
			end
			if (ph == 2) begin
				// Hold the receiver off so the block backs up into its input.
				hold_receiver = 400;
			end
			drain();
			if (ph == 3) begin
				// After everything has come back, the sender pauses before the next phase.
				repeat (50) @(posedge clk);
			end
		end

		$display("accepted %0d requests and checked %0d results over six media lengths",
			accepted_requests, checked_results);
		$display("inside %0d, gap %0d, past end %0d, full %0d, bad index %0d",
			status_seen[ST_INSIDE], status_seen[ST_GAP_DROP], status_seen[ST_PAST_END],
			status_seen[ST_FULL], status_seen[ST_BAD_INDEX]);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire
